### rtl/line_number_escape_filter_defines.svh
// ---------------------------------------------------------------------------
// Line number escape filter: assertion macros
// Shared helpers for the concurrent checks on the filter's ports.
// ---------------------------------------------------------------------------
`ifndef LINE_NUMBER_ESCAPE_FILTER_DEFINES_SVH
`define LINE_NUMBER_ESCAPE_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define LNEF_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("line number escape filter check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define LNEF_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("line number escape filter check failed");

`endif

### rtl/lnef_pkg.sv
// ---------------------------------------------------------------------------
// Line number escape filter: package
// Constants, register indexes and the configuration type of the filter.
// ---------------------------------------------------------------------------
package lnef_pkg;

   // Decimal places of the line number and depth of the word queue.
   localparam int NUMBER_DIGITS   = 6;
   localparam int QUEUE_DEPTH     = 4;
   localparam int CSR_INDEX_WIDTH = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SQUEEZE_BLANK    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NUMBER_ALL       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NUMBER_NONBLANK  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHOW_ENDS        = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHOW_TABS        = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHOW_NONPRINTING = 3'd5;

   // Character codes.
   localparam logic [7:0] CHAR_TAB      = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE  = 8'd10;
   localparam logic [7:0] CHAR_SPACE    = 8'd32;
   localparam logic [7:0] CHAR_DOLLAR   = 8'd36;
   localparam logic [7:0] CHAR_ZERO     = 8'd48;
   localparam logic [7:0] CHAR_NINE     = 8'd57;
   localparam logic [7:0] CHAR_QUESTION = 8'd63;
   localparam logic [7:0] CHAR_I        = 8'd73;
   localparam logic [7:0] CHAR_CARET    = 8'd94;
   localparam logic [7:0] CHAR_DELETE   = 8'd127;
   localparam logic [7:0] CHAR_HIGH     = 8'd128;
   localparam logic [7:0] ESCAPE_OFFSET = 8'd64;

   typedef struct packed {
      logic squeeze_blank;
      logic number_all;
      logic number_nonblank;
      logic show_ends;
      logic show_tabs;
      logic show_nonprinting;
   } cfg_type;

endpackage

### rtl/lnef_queue.sv
// ---------------------------------------------------------------------------
// Line number escape filter: word queue
// Small register-based FIFO between the classifying front and the back end.
// ---------------------------------------------------------------------------
module lnef_queue #(
   parameter int DEPTH = lnef_pkg::QUEUE_DEPTH,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/lnef_front.sv
// ---------------------------------------------------------------------------
// Line number escape filter: front end
// Accepts input words, keeps newline history and the line count, and turns
// each word that is not squeezed into a queue entry listing its output bytes.
// ---------------------------------------------------------------------------
module lnef_front #(
   parameter int NUM_DIGITS = lnef_pkg::NUMBER_DIGITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lnef_pkg::cfg_type         cfg,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [7:0]                in_data_byte,
   input  logic                      in_file_start,
   input  logic                      queue_full,
   output logic                      push,
   output logic [4*NUM_DIGITS-1:0]   push_digits,
   output logic [NUM_DIGITS-1:0]     push_blank,
   output logic [NUM_DIGITS+3:0]     push_mask,
   output logic [7:0]                push_char
);

   localparam int DW = 4 * NUM_DIGITS;

   logic          prev_nl_ff, prev_nl_in;
   logic          prev2_nl_ff, prev2_nl_in;
   logic [DW-1:0] count_ff, count_in;

   logic          cur_prev, cur_prev2, is_nl, squeeze, number, dollar, caret;
   logic          accept, carry, all_zero;
   logic [DW-1:0] cur_count, count_inc;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   // A file start restarts the history and count before this word.
   assign cur_prev  = in_file_start ? 1'b1 : prev_nl_ff;
   assign cur_prev2 = in_file_start ? 1'b0 : prev2_nl_ff;
   assign cur_count = in_file_start ? DW'(1) : count_ff;

   assign is_nl   = (in_data_byte == lnef_pkg::CHAR_NEWLINE);
   assign squeeze = cfg.squeeze_blank && cur_prev && cur_prev2 && is_nl;
   assign number  = cur_prev && (cfg.number_nonblank ? !is_nl : cfg.number_all);
   assign dollar  = cfg.show_ends && is_nl;
   assign push    = accept && !squeeze;

   always_comb begin
      caret     = 1'b0;
      push_char = in_data_byte;
      if (cfg.show_tabs && in_data_byte == lnef_pkg::CHAR_TAB) begin
         caret     = 1'b1;
         push_char = lnef_pkg::CHAR_I;
      end else if (cfg.show_nonprinting && !is_nl
                   && in_data_byte != lnef_pkg::CHAR_TAB) begin
         if (in_data_byte < lnef_pkg::CHAR_SPACE) begin
            caret     = 1'b1;
            push_char = in_data_byte + lnef_pkg::ESCAPE_OFFSET;
         end else if (in_data_byte == lnef_pkg::CHAR_DELETE) begin
            caret     = 1'b1;
            push_char = lnef_pkg::CHAR_QUESTION;
         end else if (in_data_byte >= lnef_pkg::CHAR_HIGH) begin
            push_char = in_data_byte - lnef_pkg::ESCAPE_OFFSET;
         end
      end
   end

   // Decimal increment, wrapping from all nines to zero.
   always_comb begin
      carry = 1'b1;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (carry && cur_count[4*i +: 4] == 4'd9) begin
            count_inc[4*i +: 4] = 4'd0;
         end else if (carry) begin
            count_inc[4*i +: 4] = cur_count[4*i +: 4] + 4'd1;
            carry = 1'b0;
         end else begin
            count_inc[4*i +: 4] = cur_count[4*i +: 4];
         end
      end
   end

   // Leading zeros print as spaces; the lowest digit always prints.
   always_comb begin
      all_zero = 1'b1;
      for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
         all_zero      = all_zero && (cur_count[4*i +: 4] == 4'd0);
         push_blank[i] = all_zero && (i != 0);
      end
   end

   assign push_digits = cur_count;
   assign push_mask   = {1'b1, caret, dollar, number, {NUM_DIGITS{number}}};

   always_comb begin
      prev_nl_in  = prev_nl_ff;
      prev2_nl_in = prev2_nl_ff;
      count_in    = count_ff;
      if (accept) begin
         prev_nl_in  = is_nl;
         prev2_nl_in = cur_prev;
         count_in    = (number && !squeeze) ? count_inc : cur_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_nl_ff  <= 1'b1;
         prev2_nl_ff <= 1'b0;
         count_ff    <= DW'(1);
      end else begin
         prev_nl_ff  <= prev_nl_in;
         prev2_nl_ff <= prev2_nl_in;
         count_ff    <= count_in;
      end
   end

endmodule

### rtl/lnef_back.sv
// ---------------------------------------------------------------------------
// Line number escape filter: back end
// Expands one queue entry into its output bytes, one byte per cycle while
// the output is not stalled, into a registered output stage.
// ---------------------------------------------------------------------------
module lnef_back #(
   parameter int NUM_DIGITS = lnef_pkg::NUMBER_DIGITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      queue_empty,
   output logic                      pop,
   input  logic [4*NUM_DIGITS-1:0]   entry_digits,
   input  logic [NUM_DIGITS-1:0]     entry_blank,
   input  logic [NUM_DIGITS+3:0]     entry_mask,
   input  logic [7:0]                entry_char,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [7:0]                out_byte,
   output logic                      out_last
);

   localparam int DW = 4 * NUM_DIGITS;
   localparam int PW = NUM_DIGITS + 4;

   // Work register: the entry being expanded and the bytes still owed.
   logic          work_valid_ff, work_valid_in;
   logic [PW-1:0] mask_ff, mask_in;
   logic [DW-1:0] digits_ff;
   logic [NUM_DIGITS-1:0] blank_ff;
   logic [7:0]    char_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff;
   logic          rsp_last_ff;

   logic [PW-1:0] lowest;
   logic [7:0]    sel_byte;
   logic          emit, last, load;

   assign lowest = mask_ff & (~mask_ff + 1'b1);
   assign last   = ((mask_ff & ~lowest) == '0);
   assign emit   = work_valid_ff && (!rsp_valid_ff || out_ready);
   assign load   = !queue_empty && (!work_valid_ff || (emit && last));
   assign pop    = load;

   // Positions in order: digits from the most significant, tab, dollar,
   // caret, then the character itself.
   always_comb begin
      sel_byte = '0;
      for (int j = 0; j < NUM_DIGITS; j++) begin
         if (lowest[j]) begin
            sel_byte = blank_ff[NUM_DIGITS-1-j] ? lnef_pkg::CHAR_SPACE
                     : lnef_pkg::CHAR_ZERO + {4'd0, digits_ff[4*(NUM_DIGITS-1-j) +: 4]};
         end
      end
      if (lowest[NUM_DIGITS]) begin
         sel_byte = lnef_pkg::CHAR_TAB;
      end
      if (lowest[NUM_DIGITS+1]) begin
         sel_byte = lnef_pkg::CHAR_DOLLAR;
      end
      if (lowest[NUM_DIGITS+2]) begin
         sel_byte = lnef_pkg::CHAR_CARET;
      end
      if (lowest[NUM_DIGITS+3]) begin
         sel_byte = char_ff;
      end
   end

   always_comb begin
      work_valid_in = work_valid_ff;
      mask_in       = mask_ff;
      if (load) begin
         work_valid_in = 1'b1;
         mask_in       = entry_mask;
      end else if (emit) begin
         work_valid_in = !last;
         mask_in       = mask_ff & ~lowest;
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      if (load) begin
         digits_ff <= entry_digits;
         blank_ff  <= entry_blank;
         char_ff   <= entry_char;
      end
      if (emit) begin
         rsp_byte_ff <= sel_byte;
         rsp_last_ff <= last;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_byte  = rsp_byte_ff;
   assign out_last  = rsp_last_ff;

endmodule

### rtl/line_number_escape_filter.sv
// ---------------------------------------------------------------------------
// Line number escape filter: top level
// Byte stream filter with line numbering, blank squeezing and escaping.
// ---------------------------------------------------------------------------
// Each input word carries one byte of a text stream and yields between one
// and NUMBER_DIGITS+3 output words, or none for a squeezed newline; the
// final output word of an input is flagged by rsp_last_of_run. The block
// sends one output word per cycle while rsp_ready does not stall it; an
// input word yields one output word for a plain byte and up to nine for a
// numbered line start with an escaped byte at the default six digits. A
// front end accepts a word in every cycle while its queue of QUEUE_DEPTH
// entries has room, so input keeps flowing while the back end is still
// expanding earlier words or the output is stalled.
// Configuration registers are written through the csr_ port (always ready,
// only bit 0 of the data matters, indexes above five are ignored) and must
// only be changed while no words are in flight. A word with req_file_start
// set restarts the line count at one and the newline history first.
// ---------------------------------------------------------------------------
module line_number_escape_filter #(
   parameter int NUMBER_DIGITS = lnef_pkg::NUMBER_DIGITS,
   parameter int QUEUE_DEPTH   = lnef_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_file_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_out_byte,
   output logic                                 rsp_last_of_run,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lnef_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic                                 csr_data
);

   // Queue entry: BCD digits, blank flags, byte-position mask, character.
   localparam int DW = 4 * NUMBER_DIGITS;
   localparam int PW = NUMBER_DIGITS + 4;
   localparam int EW = DW + NUMBER_DIGITS + PW + 8;

   lnef_pkg::cfg_type cfg_ff, cfg_in;

   logic                     push, pop, queue_full, queue_empty;
   logic [DW-1:0]            push_digits;
   logic [NUMBER_DIGITS-1:0] push_blank;
   logic [PW-1:0]            push_mask;
   logic [7:0]               push_char;
   logic [EW-1:0]            push_entry, pop_entry;

   // The register port never stalls.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            lnef_pkg::CSR_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = csr_data;
            lnef_pkg::CSR_NUMBER_ALL:       cfg_in.number_all       = csr_data;
            lnef_pkg::CSR_NUMBER_NONBLANK:  cfg_in.number_nonblank  = csr_data;
            lnef_pkg::CSR_SHOW_ENDS:        cfg_in.show_ends        = csr_data;
            lnef_pkg::CSR_SHOW_TABS:        cfg_in.show_tabs        = csr_data;
            lnef_pkg::CSR_SHOW_NONPRINTING: cfg_in.show_nonprinting = csr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: history, line count and classification of each word.
   lnef_front #(
      .NUM_DIGITS (NUMBER_DIGITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .in_data_byte  (req_data_byte),
      .in_file_start (req_file_start),
      .queue_full    (queue_full),
      .push          (push),
      .push_digits   (push_digits),
      .push_blank    (push_blank),
      .push_mask     (push_mask),
      .push_char     (push_char)
   );

   assign push_entry = {push_digits, push_blank, push_mask, push_char};

   lnef_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (EW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (pop),
      .pop_data  (pop_entry),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // Back end: one output word per cycle from the head entry, unless the output stalls.
   lnef_back #(
      .NUM_DIGITS (NUMBER_DIGITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_empty  (queue_empty),
      .pop          (pop),
      .entry_digits (pop_entry[EW-1 -: DW]),
      .entry_blank  (pop_entry[PW+8 +: NUMBER_DIGITS]),
      .entry_mask   (pop_entry[8 +: PW]),
      .entry_char   (pop_entry[7:0]),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_byte     (rsp_out_byte),
      .out_last     (rsp_last_of_run)
   );

endmodule

### rtl/lnef_checker.sv
// ---------------------------------------------------------------------------
// Line number escape filter: port checker
// Concurrent checks on the filter's ports, bound to the top level.
// ---------------------------------------------------------------------------
`include "line_number_escape_filter_defines.svh"

module lnef_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [7:0]                           req_data_byte,
   input logic                                 req_file_start,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [7:0]                           rsp_out_byte,
   input logic                                 rsp_last_of_run,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [lnef_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input logic                                 csr_data
);

   // A stalled output word holds.
   `LNEF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_of_run))

   // Reset empties the output stage.
   `LNEF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // A word that is not the last of its run is a digit, space, tab, '$' or '^'.
   `LNEF_ASSERT_NOW(a_prefix_bytes, clock, reset, rsp_valid && !rsp_last_of_run, rsp_out_byte == lnef_pkg::CHAR_SPACE || rsp_out_byte == lnef_pkg::CHAR_TAB || rsp_out_byte == lnef_pkg::CHAR_DOLLAR || rsp_out_byte == lnef_pkg::CHAR_CARET || (rsp_out_byte >= lnef_pkg::CHAR_ZERO && rsp_out_byte <= lnef_pkg::CHAR_NINE))

   // The rest of a run follows without a bubble once a word is taken.
   `LNEF_ASSERT_NEXT(a_run_continues, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_run, rsp_valid)

endmodule

bind line_number_escape_filter lnef_checker u_lnef_checker (.*);
